// File: rtl/lmth_pkg.sv
// Shared types and constants of the lane multiply texture hash.
`default_nettype none
package lmth_pkg;

    localparam int LANES     = 8;
    localparam int LANE_W    = 16;
    localparam int WORDS     = 4;
    localparam int WORD_W    = 32;
    localparam int CHUNK_W   = LANES * LANE_W;

    // Group phase codes.
    localparam logic [1:0] PH_MAC  = 2'd0;
    localparam logic [1:0] PH_XOR  = 2'd1;
    localparam logic [1:0] PH_ADD  = 2'd2;
    localparam logic [1:0] PH_MXOR = 2'd3;

    localparam logic [LANE_W-1:0] MULT_STEP = 16'h2455;

    // Lane 0 sits in the low bits.
    localparam logic [CHUNK_W-1:0] MULT_INIT = {
        16'h0001, 16'h0083, 16'h4309, 16'h4d9b,
        16'hb651, 16'h4b73, 16'h9bd9, 16'hc00b
    };

    typedef struct packed {
        logic [63:0] data_lo;
        logic [63:0] data_hi;
        logic        block_mode;
        logic        upper_valid;
        logic        last;
    } t_chunk;

endpackage
`default_nettype wire

// File: rtl/lmth_if.sv
// Handshake interfaces for the chunk input and the hash result.
`default_nettype none
interface lmth_chunk_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_lo;
    logic [63:0] data_hi;
    logic        block_mode;
    logic        upper_valid;
    logic        last;

    modport source (output valid, data_lo, data_hi, block_mode, upper_valid, last,
                    input ready);
    modport sink   (input valid, data_lo, data_hi, block_mode, upper_valid, last,
                    output ready);
endinterface

interface lmth_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash;
    logic        group_error;

    modport source (output valid, hash, group_error, input ready);
    modport sink   (input valid, hash, group_error, output ready);
endinterface
`default_nettype wire

// File: rtl/lane_multiply_texture_hash_top.sv
// Top level of the lane multiply texture hash.
// The block takes one 16-byte chunk per cycle when not stalled and emits one 32-bit hash
// for each chunk marked last. A chunk is registered on acceptance and folded into
// the lane state as it leaves that register (eight 16x16 multiplies in parallel); a last
// chunk then hands a snapshot of the state to a finalize stage whose eight-word adder
// sum, or in simple mode the running sum, fills the result register. The state returns
// to its initial values with the snapshot, so the next message may follow at once. Only a
// last chunk can stall, and only while the snapshot is full and the result is not taken.
`default_nettype none
module lane_multiply_texture_hash_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lmth_chunk_if.sink     i_chunk,
    lmth_result_if.source  o_result
);

    localparam int CW = lmth_pkg::CHUNK_W;
    localparam int LW = lmth_pkg::LANE_W;
    localparam int WW = lmth_pkg::WORD_W;

    // Input stage
    logic               r_s1_valid;
    lmth_pkg::t_chunk   r_s1;

    // Hash state
    logic [CW-1:0]      r_acc, n_acc;
    logic [CW-1:0]      r_mult, n_mult;
    logic [1:0]         r_phase;
    logic [WW-1:0]      r_sum, n_sum;

    // Finalize stage
    logic               r_fin_valid;
    logic               r_fin_block;
    logic               r_fin_err;
    logic [CW-1:0]      r_fin_acc;
    logic [CW-1:0]      r_fin_mult;
    logic [WW-1:0]      r_fin_sum;

    // Result register
    logic               r_out_valid;
    logic [WW-1:0]      r_out_hash;
    logic               r_out_err;

    logic               out_free, fin_free, s1_go, s1_free;
    logic [CW-1:0]      chunk;
    logic [LW-1:0]      prod [lmth_pkg::LANES];
    logic [WW-1:0]      fin_hash;

    assign out_free = !r_out_valid || o_result.ready;
    assign fin_free = !r_fin_valid || out_free;
    assign s1_go    = r_s1_valid && (!r_s1.last || fin_free);
    assign s1_free  = !r_s1_valid || s1_go;

    assign i_chunk.ready = s1_free;

    assign chunk = {r_s1.data_hi, r_s1.data_lo};

    always_comb begin
        logic [2*LW-1:0] full;
        for (int k = 0; k < lmth_pkg::LANES; k++) begin
            full    = chunk[k*LW +: LW] * r_mult[k*LW +: LW];
            prod[k] = full[LW-1:0];
        end
    end

    always_comb begin
        n_acc  = r_acc;
        n_mult = r_mult;
        case (r_phase)
            lmth_pkg::PH_MAC: begin
                for (int k = 0; k < lmth_pkg::LANES; k++)
                    n_acc[k*LW +: LW] = r_acc[k*LW +: LW] + prod[k];
            end
            lmth_pkg::PH_XOR: begin
                n_acc = r_acc ^ chunk;
            end
            lmth_pkg::PH_ADD: begin
                for (int w = 0; w < lmth_pkg::WORDS; w++)
                    n_acc[w*WW +: WW] = r_acc[w*WW +: WW] + chunk[w*WW +: WW];
            end
            lmth_pkg::PH_MXOR: begin
                for (int k = 0; k < lmth_pkg::LANES; k++) begin
                    n_acc[k*LW +: LW]  = r_acc[k*LW +: LW] ^ prod[k];
                    n_mult[k*LW +: LW] = r_mult[k*LW +: LW] + lmth_pkg::MULT_STEP;
                end
            end
            default: begin
                n_acc  = r_acc;
                n_mult = r_mult;
            end
        endcase
    end

    always_comb begin
        n_sum = r_sum + r_s1.data_lo[31:0];
        n_sum = n_sum ^ r_s1.data_lo[63:32];
        if (r_s1.upper_valid) begin
            n_sum = n_sum + r_s1.data_hi[31:0];
            n_sum = n_sum ^ r_s1.data_hi[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_chunk.valid;
        end
        if (s1_free) begin
            r_s1.data_lo     <= i_chunk.data_lo;
            r_s1.data_hi     <= i_chunk.data_hi;
            r_s1.block_mode  <= i_chunk.block_mode;
            r_s1.upper_valid <= i_chunk.upper_valid;
            r_s1.last        <= i_chunk.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_mult  <= lmth_pkg::MULT_INIT;
            r_phase <= lmth_pkg::PH_MAC;
            r_sum   <= '0;
        end else if (s1_go) begin
            if (r_s1.last) begin
                r_acc   <= '0;
                r_mult  <= lmth_pkg::MULT_INIT;
                r_phase <= lmth_pkg::PH_MAC;
                r_sum   <= '0;
            end else if (r_s1.block_mode) begin
                r_acc   <= n_acc;
                r_mult  <= n_mult;
                r_phase <= r_phase + 2'd1;
            end else begin
                r_sum   <= n_sum;
            end
        end
    end

    // Snapshot of the state as the last chunk leaves it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin_free) begin
            r_fin_valid <= s1_go && r_s1.last;
        end
        if (fin_free && s1_go && r_s1.last) begin
            r_fin_block <= r_s1.block_mode;
            r_fin_err   <= r_s1.block_mode && (r_phase != lmth_pkg::PH_MXOR);
            r_fin_acc   <= n_acc;
            r_fin_mult  <= n_mult;
            r_fin_sum   <= r_s1.block_mode ? r_sum : n_sum;
        end
    end

    always_comb begin
        fin_hash = '0;
        for (int w = 0; w < lmth_pkg::WORDS; w++)
            fin_hash = fin_hash + r_fin_acc[w*WW +: WW] + r_fin_mult[w*WW +: WW];
        if (!r_fin_block)
            fin_hash = r_fin_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_fin_valid;
        end
        if (out_free && r_fin_valid) begin
            r_out_hash <= fin_hash;
            r_out_err  <= r_fin_err;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.hash        = r_out_hash;
    assign o_result.group_error = r_out_err;

endmodule
`default_nettype wire

// File: rtl/lmth_checker.sv
// Port-level checks on the lane multiply texture hash top level.
`default_nettype none
module lmth_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_hash,
    input logic        i_out_err
);

    // A result beat that is waiting stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn while stalled");

    // The payload of a waiting result beat does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_hash) && $stable(i_out_err))
        else $error("result payload changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat offered right after reset");

    // With the result side free, the block always takes a chunk.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while the result side is free");

endmodule

bind lane_multiply_texture_hash_top lmth_checker u_lmth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_chunk.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_hash  (o_result.hash),
    .i_out_err   (o_result.group_error)
);
`default_nettype wire

// File: tb/tb_lane_multiply_texture_hash_top.sv
// Self-checking testbench for the lane multiply texture hash top level.
`timescale 1ns / 1ps
module tb_lane_multiply_texture_hash_top;

    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
    localparam int CHUNK_TARGET = 1050;

    // Lane 0 sits in the low bits.
    localparam logic [127:0] LANE_MULT_SEED = {
        16'h0001, 16'h0083, 16'h4309, 16'h4d9b,
        16'hb651, 16'h4b73, 16'h9bd9, 16'hc00b
    };
    localparam logic [15:0] LANE_MULT_BUMP = 16'h2455;

    typedef enum int {MSG_SIMPLE, MSG_BLOCK, MSG_MIXED} t_msg_kind;

    typedef struct {
        logic [31:0] hash;
        logic        group_error;
    } t_hash_result;

    logic clk;
    logic rst_n;

    lmth_chunk_if  chunk_bus ();
    lmth_result_if result_bus ();

    lane_multiply_texture_hash_top dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_chunk  (chunk_bus),
        .o_result (result_bus)
    );

    // Predicted hash state.
    logic [15:0] lane_acc [8];
    logic [15:0] lane_mult [8];
    logic [1:0]  group_phase;
    logic [31:0] simple_sum;

    lmth_pkg::t_chunk pending_chunks [$];
    t_hash_result     expected_hashes [$];
    lmth_pkg::t_chunk chunk_on_bus;
    t_hash_result     want;

    int error_count = 0;
    int send_wait   = 0;
    int send_calm   = 0;
    int take_wait   = 0;
    int take_calm   = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: MISMATCH %s", $time, what);
        error_count++;
    endtask

    task automatic clear_hash_state();
        for (int k = 0; k < 8; k++) begin
            lane_acc[k]  = '0;
            lane_mult[k] = LANE_MULT_SEED[16*k +: 16];
        end
        group_phase = lmth_pkg::PH_MAC;
        simple_sum  = '0;
    endtask

    // Folds one accepted beat into the predicted state; a last beat yields a hash.
    task automatic fold_chunk(input lmth_pkg::t_chunk c);
        logic [127:0] flat;
        logic [15:0]  ln [8];
        logic [31:0]  word;
        logic [1:0]   ph;
        t_hash_result res;
        flat = {c.data_hi, c.data_lo};
        for (int k = 0; k < 8; k++) ln[k] = flat[16*k +: 16];
        res.hash = '0;
        res.group_error = 1'b0;
        if (c.block_mode) begin
            ph = group_phase;
            case (ph)
                lmth_pkg::PH_MAC: begin
                    for (int k = 0; k < 8; k++)
                        lane_acc[k] = lane_acc[k] + ln[k] * lane_mult[k];
                end
                lmth_pkg::PH_XOR: begin
                    for (int k = 0; k < 8; k++) lane_acc[k] = lane_acc[k] ^ ln[k];
                end
                lmth_pkg::PH_ADD: begin
                    for (int w = 0; w < 4; w++) begin
                        word = {lane_acc[2*w+1], lane_acc[2*w]} + {ln[2*w+1], ln[2*w]};
                        lane_acc[2*w]   = word[15:0];
                        lane_acc[2*w+1] = word[31:16];
                    end
                end
                default: begin
                    for (int k = 0; k < 8; k++)
                        lane_acc[k] = lane_acc[k] ^ (ln[k] * lane_mult[k]);
                    for (int k = 0; k < 8; k++) lane_mult[k] = lane_mult[k] + LANE_MULT_BUMP;
                end
            endcase
            group_phase = ph + 2'd1;
            for (int w = 0; w < 4; w++) begin
                res.hash = res.hash + {lane_acc[2*w+1], lane_acc[2*w]}
                                    + {lane_mult[2*w+1], lane_mult[2*w]};
            end
            res.group_error = (ph != lmth_pkg::PH_MXOR);
        end else begin
            simple_sum = simple_sum + c.data_lo[31:0];
            simple_sum = simple_sum ^ c.data_lo[63:32];
            if (c.upper_valid) begin
                simple_sum = simple_sum + c.data_hi[31:0];
                simple_sum = simple_sum ^ c.data_hi[63:32];
            end
            res.hash = simple_sum;
        end
        if (c.last) begin
            expected_hashes.push_back(res);
            clear_hash_state();
        end
    endtask

    // Mostly back to back or short gaps, a few long ones, and now and then a calm stretch.
    function automatic int draw_pause(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return ONES;
        return {$urandom, $urandom};
    endfunction

    task automatic add_chunk(input logic [63:0] lo, input logic [63:0] hi,
                             input logic blk, input logic up, input logic lst);
        lmth_pkg::t_chunk c;
        c.data_lo     = lo;
        c.data_hi     = hi;
        c.block_mode  = blk;
        c.upper_valid = up;
        c.last        = lst;
        pending_chunks.push_back(c);
    endtask

    task automatic add_message(input t_msg_kind kind, input int n_chunks);
        logic blk;
        for (int i = 0; i < n_chunks; i++) begin
            case (kind)
                MSG_SIMPLE: blk = 1'b0;
                MSG_BLOCK:  blk = 1'b1;
                default:    blk = 1'($urandom_range(0, 1));
            endcase
            add_chunk(pick_word(), pick_word(), blk, 1'($urandom_range(0, 1)),
                      i == n_chunks - 1);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            chunk_bus.valid <= 1'b0;
        end else begin
            if (chunk_bus.valid && chunk_bus.ready) fold_chunk(chunk_on_bus);
            if (!chunk_bus.valid || chunk_bus.ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    chunk_bus.valid <= 1'b0;
                end else if (pending_chunks.size() != 0) begin
                    chunk_on_bus = pending_chunks.pop_front();
                    chunk_bus.data_lo     <= chunk_on_bus.data_lo;
                    chunk_bus.data_hi     <= chunk_on_bus.data_hi;
                    chunk_bus.block_mode  <= chunk_on_bus.block_mode;
                    chunk_bus.upper_valid <= chunk_on_bus.upper_valid;
                    chunk_bus.last        <= chunk_on_bus.last;
                    chunk_bus.valid       <= 1'b1;
                    send_wait = draw_pause(send_calm);
                end else begin
                    chunk_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch($sformatf("unexpected hash beat %h", result_bus.hash));
                end else begin
                    want = expected_hashes.pop_front();
                    if (result_bus.hash !== want.hash)
                        report_mismatch($sformatf("hash got %h expected %h",
                                                  result_bus.hash, want.hash));
                    if (result_bus.group_error !== want.group_error)
                        report_mismatch($sformatf("group_error got %b expected %b",
                                                  result_bus.group_error, want.group_error));
                end
            end
            if (take_wait > 0) begin
                take_wait--;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
                take_wait = draw_pause(take_calm);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int r;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        chunk_bus.valid       = 1'b0;
        chunk_bus.data_lo     = '0;
        chunk_bus.data_hi     = '0;
        chunk_bus.block_mode  = 1'b0;
        chunk_bus.upper_valid = 1'b0;
        chunk_bus.last        = 1'b0;
        result_bus.ready      = 1'b0;
        clear_hash_state();

        // Two full groups of zero and all-ones chunks, so the multipliers get bumped.
        for (int i = 0; i < 8; i++)
            add_chunk(i % 2 ? ONES : '0, i % 2 ? ONES : '0, 1'b1, 1'(i % 2), i == 7);
        // Messages that stop in the first, second and third phase of a group.
        add_chunk(ONES, ONES, 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < 2; i++) add_chunk(pick_word(), pick_word(), 1'b1, 1'b0, i == 1);
        for (int i = 0; i < 3; i++) add_chunk(pick_word(), pick_word(), 1'b1, 1'b1, i == 2);
        // Simple mode without and with the upper pair.
        add_chunk(ONES, ONES, 1'b0, 1'b0, 1'b1);
        add_chunk(ONES, ONES, 1'b0, 1'b1, 1'b1);
        // Mixed modes: the mode of the last chunk forms the hash.
        add_chunk(pick_word(), pick_word(), 1'b0, 1'b1, 1'b0);
        add_chunk(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0);
        add_chunk(pick_word(), pick_word(), 1'b1, 1'b1, 1'b1);
        add_chunk(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0);
        add_chunk(pick_word(), pick_word(), 1'b0, 1'b1, 1'b1);
        // An all-ones group with upper_valid set, which block mode ignores.
        for (int i = 0; i < 4; i++) add_chunk(ONES, ONES, 1'b1, 1'b1, i == 3);

        while (pending_chunks.size() < CHUNK_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                add_message(MSG_BLOCK, 4 * ($urandom_range(0, 9) == 0 ? $urandom_range(5, 12)
                                                                     : $urandom_range(1, 4)));
            else if (r < 75)
                add_message(MSG_SIMPLE, $urandom_range(1, 8));
            else if (r < 88)
                add_message(MSG_BLOCK, 4 * $urandom_range(0, 3) + $urandom_range(1, 3));
            else
                add_message(MSG_MIXED, $urandom_range(1, 8));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk); while (pending_chunks.size() != 0 || chunk_bus.valid);
        while (expected_hashes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: lane_multiply_texture_hash_top.f
rtl/lmth_pkg.sv
rtl/lmth_if.sv
rtl/lane_multiply_texture_hash_top.sv
rtl/lmth_checker.sv
tb/tb_lane_multiply_texture_hash_top.sv
